[hw/rtl/htm_pkg.sv]
package htm_pkg;

    localparam int TEMP_W      = 24;
    localparam int GAIN_W      = 24;
    localparam int DT_W        = 22;
    localparam int DUTY_W      = 17;
    localparam int EXTRA_W     = 18;
    localparam int RATE_W      = 26;
    localparam int MUL_W       = 32;
    localparam int PROD_W      = 64;
    localparam int NODE_SUM_W  = 40;
    localparam int DIV_W       = 52;
    localparam int DVS_W       = 26;
    localparam int CNT_W       = 6;
    localparam int CFG_IDX_W   = 3;
    localparam int NUM_REGS    = 8;
    localparam int IN_TDATA_W  = 112;
    localparam int OUT_TDATA_W = 104;

    localparam logic signed [TEMP_W-1:0] NODE_MIN = -24'sd2621440;
    localparam logic signed [TEMP_W-1:0] NODE_MAX = 24'sd7864320;
    localparam logic signed [TEMP_W-1:0] S24_MIN  = -24'sd8388608;
    localparam logic signed [TEMP_W-1:0] S24_MAX  = 24'sd8388607;
    localparam logic signed [RATE_W-1:0] RATE_LIM = 26'sd20971520;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_AIR_WALL  = 3'd0,
        REG_CORE_AIR  = 3'd1,
        REG_FIRE      = 3'd2,
        REG_WALL_OUT  = 3'd3,
        REG_OAT_LO    = 3'd4,
        REG_OAT_HI    = 3'd5,
        REG_SUPPLY_LO = 3'd6,
        REG_SUPPLY_HI = 3'd7
    } t_reg;

    typedef enum logic [4:0] {
        OP_NONE, OP_MUL_CURVE, OP_DIV_CURVE, OP_TB,
        OP_RS1, OP_RS2, OP_RS3, OP_DIV_WALL, OP_WALL,
        OP_RS4, OP_RS5, OP_RS6, OP_DIV_CORE, OP_CORE,
        OP_D1, OP_D2, OP_D3, OP_D4, OP_D5, OP_D6, OP_D7, OP_D8,
        OP_D9, OP_D10, OP_D11, OP_D12, OP_D13, OP_D14, OP_D15
    } t_op;

    typedef enum logic [4:0] {
        S_IDLE, S_CMUL, S_CDIV, S_CWAIT, S_TB,
        S_R1, S_R2, S_R3, S_WDIV, S_WWAIT, S_WALL,
        S_R4, S_R5, S_R6, S_KDIV, S_KWAIT, S_CORE,
        S_D1, S_D2, S_D3, S_D4, S_D5, S_D6, S_D7,
        S_D8, S_D9, S_D10, S_D11, S_D12, S_D13, S_D14, S_OUT
    } t_state;

    typedef struct packed {
        t_op  op;
        logic load;
    } t_cmd;

    typedef struct packed {
        logic restart;
        logic div_done;
        logic out_free;
    } t_sts;

    function automatic logic signed [PROD_W-1:0] rnd_sh24(input logic signed [PROD_W-1:0] v);
        return (v + 64'sd8388608) >>> 24;
    endfunction

    function automatic logic signed [PROD_W-1:0] rnd_sh16(input logic signed [PROD_W-1:0] v);
        return (v + 64'sd32768) >>> 16;
    endfunction

    function automatic logic signed [TEMP_W-1:0] clamp_node(
        input logic signed [NODE_SUM_W-1:0] v);
        if (v < NODE_SUM_W'(NODE_MIN)) begin
            return NODE_MIN;
        end else if (v > NODE_SUM_W'(NODE_MAX)) begin
            return NODE_MAX;
        end
        return TEMP_W'(v);
    endfunction

endpackage

[hw/rtl/htm_div.sv]
module htm_div
    import htm_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_start,
    input  logic signed [DIV_W-1:0] i_dividend,
    input  logic signed [DVS_W-1:0] i_divisor,
    output logic                    o_done,
    output logic signed [DIV_W-1:0] o_quot
);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic             r_neg;
    logic [DIV_W-1:0] r_quo;
    logic [DVS_W-1:0] r_dvs;
    logic [DVS_W-1:0] r_rem;
    logic [DVS_W:0]   trial;
    logic             ge;

    // restoring division on magnitudes, one quotient bit a cycle
    assign trial = {r_rem, r_quo[DIV_W-1]};
    assign ge    = trial >= {1'b0, r_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(DIV_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_neg <= i_dividend[DIV_W-1] ^ i_divisor[DVS_W-1];
            r_quo <= i_dividend[DIV_W-1] ? DIV_W'(-i_dividend) : DIV_W'(i_dividend);
            r_dvs <= i_divisor[DVS_W-1] ? DVS_W'(-i_divisor) : DVS_W'(i_divisor);
            r_rem <= '0;
        end else if (r_busy) begin
            r_rem <= ge ? DVS_W'(trial - {1'b0, r_dvs}) : DVS_W'(trial);
            r_quo <= {r_quo[DIV_W-2:0], ge};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_neg ? -signed'(r_quo) : signed'(r_quo);

endmodule

[hw/rtl/htm_dp.sv]
module htm_dp
    import htm_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  t_cmd                   i_cmd,
    output t_sts                   o_sts,
    input  logic                   i_restart,
    input  logic [IN_TDATA_W-1:0]  i_data,
    input  logic                   i_cfg_we,
    input  logic [CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [GAIN_W-1:0]      i_cfg_data,
    input  logic                   i_out_ready,
    output logic                   o_out_valid,
    output logic [OUT_TDATA_W-1:0] o_out_data
);

    logic [GAIN_W-1:0] r_cfg [NUM_REGS];

    logic                     r_restart;
    logic [DT_W-1:0]          r_dt;
    logic signed [TEMP_W-1:0] r_meas;
    logic [DUTY_W-1:0]        r_duty;
    logic signed [EXTRA_W-1:0] r_extra;
    logic signed [TEMP_W-1:0] r_oat;

    logic signed [TEMP_W-1:0] r_wall, r_air, r_core, r_tb;
    logic signed [MUL_W-1:0]  r_w16, r_a16, r_c16, r_heat;
    logic signed [PROD_W-1:0] r_acc, r_prod;

    logic                     r_ovalid;
    logic signed [RATE_W-1:0] r_orate;
    logic signed [TEMP_W-1:0] r_oair, r_owall, r_ocore;

    logic [GAIN_W-1:0]        ha, hc, hf, ho;
    logic signed [TEMP_W-1:0] rn, rx, tn, tx, lo, hi;
    logic signed [MUL_W-1:0]  mul_a, mul_b;
    logic                     div_start, div_done;
    logic signed [DIV_W-1:0]  div_num, div_q, tb_full;
    logic signed [DVS_W-1:0]  div_den;
    logic signed [TEMP_W-1:0] node_new;
    logic signed [PROD_W-1:0] incr;
    logic                     out_free;

    assign ha = r_cfg[REG_AIR_WALL];
    assign hc = r_cfg[REG_CORE_AIR];
    assign hf = r_cfg[REG_FIRE];
    assign ho = r_cfg[REG_WALL_OUT];
    assign rn = signed'(r_cfg[REG_OAT_LO]);
    assign rx = signed'(r_cfg[REG_OAT_HI]);
    assign tn = signed'(r_cfg[REG_SUPPLY_LO]);
    assign tx = signed'(r_cfg[REG_SUPPLY_HI]);
    assign lo = (tn < tx) ? tn : tx;
    assign hi = (tn < tx) ? tx : tn;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_REGS; i++) begin
                r_cfg[i] <= '0;
            end
        end else if (i_cfg_we) begin
            r_cfg[i_cfg_index] <= i_cfg_data;
        end
    end

    // shared multiplier operands
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (i_cmd.op)
            OP_MUL_CURVE: begin
                mul_a = MUL_W'(r_oat) - MUL_W'(rn);
                mul_b = MUL_W'(tx) - MUL_W'(tn);
            end
            OP_RS1: begin mul_a = MUL_W'(r_oat);  mul_b = MUL_W'(ho); end
            OP_RS2: begin mul_a = MUL_W'(r_meas); mul_b = MUL_W'(ha); end
            OP_RS4: begin mul_a = MUL_W'(r_air);  mul_b = MUL_W'(ha) + MUL_W'(hc); end
            OP_RS5: begin mul_a = MUL_W'(r_wall); mul_b = MUL_W'(ha); end
            OP_D1:  begin mul_a = MUL_W'(r_air) - MUL_W'(r_wall);  mul_b = MUL_W'(ha); end
            OP_D2:  begin mul_a = MUL_W'(r_oat) - MUL_W'(r_wall);  mul_b = MUL_W'(ho); end
            OP_D4:  begin mul_a = MUL_W'(r_wall) - MUL_W'(r_air);  mul_b = MUL_W'(ha); end
            OP_D5:  begin mul_a = MUL_W'(r_core) - MUL_W'(r_air);  mul_b = MUL_W'(hc); end
            OP_D7:  begin mul_a = MUL_W'(r_duty); mul_b = MUL_W'(r_tb) - MUL_W'(r_core); end
            OP_D9:  begin mul_a = MUL_W'(r_air) - MUL_W'(r_core);  mul_b = MUL_W'(hc); end
            OP_D10: begin mul_a = r_heat; mul_b = MUL_W'(hf); end
            OP_D12: begin mul_a = r_w16;  mul_b = MUL_W'(r_dt); end
            OP_D13: begin mul_a = r_a16;  mul_b = MUL_W'(r_dt); end
            OP_D14: begin mul_a = r_c16;  mul_b = MUL_W'(r_dt); end
            default: begin mul_a = '0; mul_b = '0; end
        endcase
    end

    always_comb begin
        div_start = 1'b1;
        div_num   = DIV_W'(r_acc);
        div_den   = '0;
        case (i_cmd.op)
            OP_DIV_CURVE: begin
                div_num = DIV_W'(r_prod);
                div_den = DVS_W'(rx) - DVS_W'(rn);
            end
            OP_DIV_WALL: div_den = DVS_W'(ho) + DVS_W'(ha);
            OP_DIV_CORE: div_den = DVS_W'(hc);
            default:     div_start = 1'b0;
        endcase
    end

    htm_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_num),
        .i_divisor  (div_den),
        .o_done     (div_done),
        .o_quot     (div_q)
    );

    assign tb_full  = div_q + DIV_W'(tn);
    assign incr     = rnd_sh16(r_prod);
    always_comb begin
        node_new = '0;
        case (i_cmd.op)
            OP_D13:  node_new = clamp_node(NODE_SUM_W'(r_wall) + NODE_SUM_W'(incr));
            OP_D14:  node_new = clamp_node(NODE_SUM_W'(r_air) + NODE_SUM_W'(incr));
            default: node_new = clamp_node(NODE_SUM_W'(r_core) + NODE_SUM_W'(incr));
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_restart <= i_restart;
            r_dt      <= i_data[21:0];
            r_meas    <= signed'(i_data[45:22]);
            r_duty    <= i_data[62:46];
            r_extra   <= signed'(i_data[80:63]);
            r_oat     <= signed'(i_data[104:81]);
        end
        if (i_cmd.op != OP_NONE) begin
            r_prod <= mul_a * mul_b;
        end
        case (i_cmd.op)
            OP_TB: begin
                if (rx == rn) begin
                    r_tb <= tn;
                end else if (tb_full < DIV_W'(lo)) begin
                    r_tb <= lo;
                end else if (tb_full > DIV_W'(hi)) begin
                    r_tb <= hi;
                end else begin
                    r_tb <= TEMP_W'(tb_full);
                end
            end
            OP_RS2, OP_RS5, OP_D2, OP_D5: r_acc <= r_prod;
            OP_RS3, OP_D3, OP_D6, OP_D11: r_acc <= r_acc + r_prod;
            OP_RS6: r_acc <= r_acc - r_prod;
            OP_D4:  r_w16 <= MUL_W'(rnd_sh24(r_acc));
            OP_D7:  r_a16 <= MUL_W'(rnd_sh24(r_acc));
            OP_D8:  r_heat <= MUL_W'(rnd_sh16(r_prod));
            // conduction term plus extra heat scaled to the gain fraction
            OP_D10: r_acc <= r_prod + (PROD_W'(r_extra) <<< 24);
            OP_D12: r_c16 <= MUL_W'(rnd_sh24(r_acc));
            default: ;
        endcase
    end

    // node state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wall <= '0;
            r_air  <= '0;
            r_core <= '0;
        end else begin
            case (i_cmd.op)
                OP_RS1: r_air <= r_meas;
                OP_WALL: begin
                    if (ho != '0 || ha != '0) begin
                        r_wall <= TEMP_W'(div_q);
                    end
                end
                OP_CORE: begin
                    if (hc != '0) begin
                        if (div_q < DIV_W'(S24_MIN)) begin
                            r_core <= S24_MIN;
                        end else if (div_q > DIV_W'(S24_MAX)) begin
                            r_core <= S24_MAX;
                        end else begin
                            r_core <= TEMP_W'(div_q);
                        end
                    end
                end
                OP_D13: r_wall <= node_new;
                OP_D14: r_air  <= node_new;
                OP_D15: r_core <= node_new;
                default: ;
            endcase
        end
    end

    // output register
    assign out_free = !r_ovalid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (i_cmd.op == OP_D15) begin
            r_ovalid <= 1'b1;
        end else if (i_out_ready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.op == OP_D15) begin
            if (r_a16 > MUL_W'(RATE_LIM)) begin
                r_orate <= RATE_LIM;
            end else if (r_a16 < -MUL_W'(RATE_LIM)) begin
                r_orate <= -RATE_LIM;
            end else begin
                r_orate <= RATE_W'(r_a16);
            end
            r_oair  <= r_air;
            r_owall <= r_wall;
            r_ocore <= node_new;
        end
    end

    assign o_out_valid = r_ovalid;
    assign o_out_data  = {6'b0, r_ocore, r_owall, r_oair, r_orate};

    assign o_sts.restart  = r_restart;
    assign o_sts.div_done = div_done;
    assign o_sts.out_free = out_free;

endmodule

[hw/rtl/htm_ctrl.sv]
module htm_ctrl
    import htm_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_s_valid,
    output logic o_s_ready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:  if (i_s_valid) n_state = S_CMUL;
            S_CMUL:  n_state = S_CDIV;
            S_CDIV:  n_state = S_CWAIT;
            S_CWAIT: if (i_sts.div_done) n_state = S_TB;
            S_TB:    n_state = i_sts.restart ? S_R1 : S_D1;
            S_R1:    n_state = S_R2;
            S_R2:    n_state = S_R3;
            S_R3:    n_state = S_WDIV;
            S_WDIV:  n_state = S_WWAIT;
            S_WWAIT: if (i_sts.div_done) n_state = S_WALL;
            S_WALL:  n_state = S_R4;
            S_R4:    n_state = S_R5;
            S_R5:    n_state = S_R6;
            S_R6:    n_state = S_KDIV;
            S_KDIV:  n_state = S_KWAIT;
            S_KWAIT: if (i_sts.div_done) n_state = S_CORE;
            S_CORE:  n_state = S_D1;
            S_D1:    n_state = S_D2;
            S_D2:    n_state = S_D3;
            S_D3:    n_state = S_D4;
            S_D4:    n_state = S_D5;
            S_D5:    n_state = S_D6;
            S_D6:    n_state = S_D7;
            S_D7:    n_state = S_D8;
            S_D8:    n_state = S_D9;
            S_D9:    n_state = S_D10;
            S_D10:   n_state = S_D11;
            S_D11:   n_state = S_D12;
            S_D12:   n_state = S_D13;
            S_D13:   n_state = S_D14;
            S_D14:   n_state = S_OUT;
            S_OUT:   if (i_sts.out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_s_ready  = 1'b0;
        o_cmd.load = 1'b0;
        o_cmd.op   = OP_NONE;
        unique case (r_state)
            S_IDLE: begin
                o_s_ready  = 1'b1;
                o_cmd.load = i_s_valid;
            end
            S_CMUL:  o_cmd.op = OP_MUL_CURVE;
            S_CDIV:  o_cmd.op = OP_DIV_CURVE;
            S_TB:    o_cmd.op = OP_TB;
            S_R1:    o_cmd.op = OP_RS1;
            S_R2:    o_cmd.op = OP_RS2;
            S_R3:    o_cmd.op = OP_RS3;
            S_WDIV:  o_cmd.op = OP_DIV_WALL;
            S_WALL:  o_cmd.op = OP_WALL;
            S_R4:    o_cmd.op = OP_RS4;
            S_R5:    o_cmd.op = OP_RS5;
            S_R6:    o_cmd.op = OP_RS6;
            S_KDIV:  o_cmd.op = OP_DIV_CORE;
            S_CORE:  o_cmd.op = OP_CORE;
            S_D1:    o_cmd.op = OP_D1;
            S_D2:    o_cmd.op = OP_D2;
            S_D3:    o_cmd.op = OP_D3;
            S_D4:    o_cmd.op = OP_D4;
            S_D5:    o_cmd.op = OP_D5;
            S_D6:    o_cmd.op = OP_D6;
            S_D7:    o_cmd.op = OP_D7;
            S_D8:    o_cmd.op = OP_D8;
            S_D9:    o_cmd.op = OP_D9;
            S_D10:   o_cmd.op = OP_D10;
            S_D11:   o_cmd.op = OP_D11;
            S_D12:   o_cmd.op = OP_D12;
            S_D13:   o_cmd.op = OP_D13;
            S_D14:   o_cmd.op = OP_D14;
            // last node write and result load wait for a free output register
            S_OUT:   o_cmd.op = i_sts.out_free ? OP_D15 : OP_NONE;
            default: o_cmd.op = OP_NONE;
        endcase
    end

endmodule

[hw/rtl/house_thermal_model_step_unit.sv]
// One item at a time; an item with restart also runs the wall and core
//   initialisation steps before the update.
// The serial divider and the shared 32x32 multiplier are reused across the steps.
// A new item is taken once the previous one is loaded into the output register.
// Reset (i_rst_n low, synchronous) clears the config registers and nodes to zero and idles the controller.
module house_thermal_model_step_unit
    import htm_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_s_tvalid,
    output logic                   o_s_tready,
    // step_time, measured_air, duty, extra_heat, outdoor_temp, zero pad
    input  logic [IN_TDATA_W-1:0]  i_s_tdata,
    // restart
    input  logic                   i_s_tuser,
    output logic                   o_m_tvalid,
    input  logic                   i_m_tready,
    // air_rate, air_temp, wall_temp, core_temp, zero pad
    output logic [OUT_TDATA_W-1:0] o_m_tdata,
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [GAIN_W-1:0]      i_cfg_data
);

    t_cmd cmd;
    t_sts sts;

    assign o_cfg_ready = 1'b1;

    htm_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_valid (i_s_tvalid),
        .o_s_ready (o_s_tready),
        .i_sts     (sts),
        .o_cmd     (cmd)
    );

    htm_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_restart   (i_s_tuser),
        .i_data      (i_s_tdata),
        .i_cfg_we    (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_out_ready (i_m_tready),
        .o_out_valid (o_m_tvalid),
        .o_out_data  (o_m_tdata)
    );

`ifndef SYNTHESIS
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && o_s_tready |=> !o_s_tready)
        else $error("input accepted while an item is in work");

    a_air_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> ($signed(o_m_tdata[49:26]) >= NODE_MIN
                        && $signed(o_m_tdata[49:26]) <= NODE_MAX))
        else $error("air node outside clamp range");

    a_rate_saturated: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> ($signed(o_m_tdata[25:0]) >= -RATE_LIM
                        && $signed(o_m_tdata[25:0]) <= RATE_LIM))
        else $error("air rate outside saturation limit");
`endif

endmodule
